// ===== src/sine_tone_generator_core_assert.svh =====
// Assertion macros for the sine tone generator core.
// Used by sine_tone_generator_core.sv; expects clk and rst in scope.
`ifndef SINE_TONE_GENERATOR_CORE_ASSERT_SVH
`define SINE_TONE_GENERATOR_CORE_ASSERT_SVH

// same-cycle implication
`define STG_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define STG_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/stg_pkg.sv =====
// Shared types, constants and elaboration-time table math for the tone generator.
// No dependencies.
package stg_pkg;

  localparam int PHASE_W    = 32;
  localparam int STEP_W     = 31;
  localparam int MS_W       = 16;
  localparam int SAMPLE_W   = 16;
  localparam int AMPL_W     = 15;
  localparam int BUDGET_W   = 22;
  localparam int MS_PER_S   = 1000;
  localparam int AMPL_MAX   = 32767;

  localparam logic [BUDGET_W-1:0] BUDGET_MAX = '1;

  localparam int STG_TABLE_BITS    = 12;
  localparam int STG_BLOCK_SAMPLES = 256;
  localparam int STG_RATE_HZ       = 44100;

  localparam logic [63:0] ONE_Q60 = 64'd1 << 60;
  localparam logic [63:0] PI_Q60  = 64'h3243F6A8885A308D;

  typedef enum logic {
    ACT_START = 1'b0,
    ACT_TICK  = 1'b1
  } action_t;

  // (a*b) >> s on the full 128-bit product
  function automatic logic [63:0] mul_shr(logic [63:0] a, logic [63:0] b, int unsigned s);
    logic [127:0] p;
    p = {64'd0, a} * {64'd0, b};
    p = p >> s;
    return p[63:0];
  endfunction

  // restoring division, elaboration use only
  function automatic logic [63:0] udiv64(logic [63:0] n, logic [63:0] d);
    logic [63:0] q;
    logic [64:0] rem;
    q   = '0;
    rem = '0;
    for (int i = 63; i >= 0; i--) begin
      rem = {rem[63:0], n[i]};
      if (rem >= {1'b0, d}) begin
        rem  = rem - {1'b0, d};
        q[i] = 1'b1;
      end
    end
    return q;
  endfunction

  // Taylor series for sin or cos in Q60, argument in [0, pi/4]
  function automatic logic [63:0] series(logic [63:0] x, logic want_cos);
    logic [63:0] x2;
    logic [63:0] term;
    logic [63:0] sum;
    logic [63:0] k;
    logic        sub;
    x2   = mul_shr(x, x, 60);
    term = want_cos ? ONE_Q60 : x;
    sum  = term;
    k    = want_cos ? 64'd1 : 64'd2;
    sub  = 1'b1;
    while (term != '0 && k < 64'd60) begin
      term = udiv64(mul_shr(term, x2, 60), k * (k + 64'd1));
      sum  = sub ? sum - term : sum + term;
      sub  = !sub;
      k    = k + 64'd2;
    end
    return sum;
  endfunction

  // one quarter-wave entry, truncated toward zero and scaled by 32767
  function automatic logic [AMPL_W-1:0] qwave_entry(int unsigned m, int unsigned tb);
    logic [63:0] quarter;
    logic [63:0] half_pi;
    logic [63:0] s;
    quarter = 64'd1 << (tb - 2);
    half_pi = PI_Q60 >> 1;
    if (m == 0) begin
      s = '0;
    end else if (64'(m) == quarter) begin
      s = ONE_Q60;
    end else if (64'(2 * m) <= quarter) begin
      s = series(mul_shr(half_pi, 64'(m), tb - 2), 1'b0);
    end else begin
      s = series(mul_shr(half_pi, quarter - 64'(m), tb - 2), 1'b1);
    end
    s = mul_shr(s, 64'(AMPL_MAX), 60);
    return (s > 64'(AMPL_MAX)) ? AMPL_W'(AMPL_MAX) : AMPL_W'(s);
  endfunction

endpackage

// ===== src/stg_if.sv =====
// Valid/ready channel interfaces: note commands in, audio samples out.
// Depends on stg_pkg.
interface stg_cmd_if import stg_pkg::*; ();
  logic                valid;
  logic                ready;
  action_t             action;
  logic [STEP_W-1:0]   phase_step;
  logic [MS_W-1:0]     note_ms;

  modport source (output valid, action, phase_step, note_ms, input ready);
  modport sink   (input valid, action, phase_step, note_ms, output ready);
endinterface

interface stg_audio_if import stg_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] sample;
  logic                       last;

  modport source (output valid, sample, last, input ready);
  modport sink   (input valid, sample, last, output ready);
endinterface

// ===== src/stg_sine_rom.sv =====
// Quarter-wave sine ROM with registered read, contents built at elaboration.
// Depends on stg_pkg (qwave_entry).
module stg_sine_rom import stg_pkg::*; #(
  parameter int TABLE_BITS = STG_TABLE_BITS
) (
  input  logic                    clk,
  input  logic                    en,
  input  logic [TABLE_BITS-2:0]   addr,
  output logic [AMPL_W-1:0]       data
);

  localparam int QUARTER = 1 << (TABLE_BITS - 2);

  typedef logic [AMPL_W-1:0] rom_t [0:QUARTER];

  function automatic rom_t build_rom();
    rom_t r;
    for (int m = 0; m <= QUARTER; m++) begin
      r[m] = qwave_entry(m, TABLE_BITS);
    end
    return r;
  endfunction

  localparam rom_t ROM = build_rom();

  always_ff @(posedge clk) begin
    if (en) begin
      data <= ROM[addr];
    end
  end

endmodule

// ===== src/stg_budget.sv =====
// Note length to sample budget: floor(rate*ms/1000), rounded up to a block, saturated.
// Constant divisions done as reciprocal multiplies over a 7-stage pipeline. Uses stg_pkg.
module stg_budget import stg_pkg::*; #(
  parameter int BLOCK_SAMPLES = STG_BLOCK_SAMPLES,
  parameter int RATE_HZ       = STG_RATE_HZ
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic [MS_W-1:0]     note_ms,
  output logic                busy,
  output logic                done,
  output logic [BUDGET_W-1:0] budget
);

  localparam int NSTG = 7;

  // ms = q*1000 + r
  localparam int QW  = $clog2(((1 << MS_W) - 1) / MS_PER_S + 1);
  localparam int RMW = $clog2(MS_PER_S);
  localparam int RW  = $clog2(RATE_HZ + 1);

  // x/D == (x*M) >> S, exact for x < 2^N when S = N + clog2(D), M = 2^S/D + 1
  localparam int S1 = MS_W + RMW;
  localparam longint unsigned M1 = (64'd1 << S1) / MS_PER_S + 1;
  localparam int M1W = $clog2(M1 + 1);
  localparam int P1W = MS_W + M1W;

  localparam int N2 = RW + RMW;
  localparam int S2 = N2 + RMW;
  localparam longint unsigned M2 = (64'd1 << S2) / MS_PER_S + 1;
  localparam int M2W = $clog2(M2 + 1);
  localparam int P5W = N2 + M2W;
  localparam int P3W = RW + QW;

  localparam int N3 = RW + QW + 1;
  localparam int S3 = N3 + $clog2(BLOCK_SAMPLES);
  localparam longint unsigned M3 = (64'd1 << S3) / BLOCK_SAMPLES + 1;
  localparam int M3W = $clog2(M3 + 1);
  localparam int P4W = N3 + M3W;
  localparam int BW  = $clog2(BLOCK_SAMPLES + 1);
  localparam int RNW = N3 + BW;

  logic [NSTG-1:0] stage_v;

  logic [MS_W-1:0] ms_r;
  logic [MS_W-1:0] ms_d;
  logic [P1W-1:0]  p1;
  logic [QW-1:0]   q;
  logic [MS_W-1:0] q_ms;
  logic [QW-1:0]   q_r;
  logic [RMW-1:0]  r_r;
  logic [N2-1:0]   p2;
  logic [P3W-1:0]  p3;
  logic [P3W-1:0]  p3_d;
  logic [P5W-1:0]  p5;
  logic [N3-1:0]   total;
  logic [P4W-1:0]  p4;
  logic [N3-1:0]   qb;
  logic [RNW-1:0]  rounded;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_v <= '0;
    end else begin
      stage_v <= {stage_v[NSTG-2:0], start};
    end
  end

  assign q    = QW'(p1 >> S1);
  assign q_ms = MS_W'(q) * MS_W'(MS_PER_S);

  always_ff @(posedge clk) begin
    if (start) begin
      ms_r <= note_ms;
    end
    p1    <= P1W'(ms_r) * P1W'(M1);
    ms_d  <= ms_r;
    q_r   <= q;
    r_r   <= RMW'(ms_d - q_ms);
    p2    <= N2'(r_r) * N2'(RATE_HZ);
    p3    <= P3W'(q_r) * P3W'(RATE_HZ);
    p5    <= P5W'(p2) * P5W'(M2);
    p3_d  <= p3;
    total <= N3'(p3_d) + N3'(p5 >> S2) + N3'(BLOCK_SAMPLES - 1);
    p4    <= P4W'(total) * P4W'(M3);
  end

  assign qb      = N3'(p4 >> S3);
  assign rounded = RNW'(qb) * RNW'(BLOCK_SAMPLES);

  always_comb begin
    if (rounded > RNW'(BUDGET_MAX)) begin
      budget = BUDGET_MAX;
    end else begin
      budget = BUDGET_W'(rounded);
    end
  end

  assign busy = |stage_v;
  assign done = stage_v[NSTG-1];

endmodule

// ===== src/sine_tone_generator_core.sv =====
// Sine tone generator (direct digital synthesis), one note at a time. A start
// transaction on cmd clears the 32-bit phase, latches phase_step and computes the
// sample budget; each tick transaction then yields one sample on audio, last set on
// the final one, while ticks with the budget spent yield nothing. Ticks are taken
// one per clock while audio is not stalled and no budget is being computed; a
// sample reaches audio through the registered quarter-wave ROM read, addressed
// from the phase register, and the output register. A start holds cmd.ready low
// while the budget pipeline (three reciprocal-multiply divisions) runs.
// Depends on stg_pkg, stg_if, stg_budget, stg_sine_rom and the assert header.
`include "sine_tone_generator_core_assert.svh"

module sine_tone_generator_core import stg_pkg::*; #(
  parameter int TABLE_BITS    = STG_TABLE_BITS,
  parameter int BLOCK_SAMPLES = STG_BLOCK_SAMPLES,
  parameter int RATE_HZ       = STG_RATE_HZ
) (
  input  logic          clk,
  input  logic          rst,
  stg_cmd_if.sink       cmd,
  stg_audio_if.source   audio
);

  localparam int AW = TABLE_BITS - 1;
  localparam logic [AW-1:0] QUARTER = AW'(1 << (TABLE_BITS - 2));

  logic [PHASE_W-1:0]  phase_acc;
  logic [BUDGET_W-1:0] samples_left;
  logic [STEP_W-1:0]   step_hold;

  logic                bud_busy;
  logic                bud_done;
  logic [BUDGET_W-1:0] bud_value;

  logic cmd_fire;
  logic start_fire;
  logic tick_fire;
  logic advance;

  logic [TABLE_BITS-1:0] idx;
  logic [AW-1:0]         m_ext;
  logic [AW-1:0]         rom_addr;
  logic [AMPL_W-1:0]     rom_data;

  logic s1_valid;
  logic s1_neg;
  logic s1_zero;
  logic s1_last;

  logic                       out_valid;
  logic signed [SAMPLE_W-1:0] out_sample;
  logic                       out_last;
  logic [SAMPLE_W-1:0]        mag;

  assign advance    = !out_valid || audio.ready;
  assign cmd.ready  = !bud_busy && (!s1_valid || advance);
  assign cmd_fire   = cmd.valid && cmd.ready;
  assign start_fire = cmd_fire && (cmd.action == ACT_START);
  assign tick_fire  = cmd_fire && (cmd.action == ACT_TICK) && (samples_left != '0);

  stg_budget #(
    .BLOCK_SAMPLES (BLOCK_SAMPLES),
    .RATE_HZ       (RATE_HZ)
  ) u_budget (
    .clk     (clk),
    .rst     (rst),
    .start   (start_fire),
    .note_ms (cmd.note_ms),
    .busy    (bud_busy),
    .done    (bud_done),
    .budget  (bud_value)
  );

  // note state
  always_ff @(posedge clk) begin
    if (rst) begin
      phase_acc    <= '0;
      samples_left <= '0;
      step_hold    <= '0;
    end else begin
      if (start_fire) begin
        phase_acc <= '0;
        step_hold <= cmd.phase_step;
      end
      if (bud_done) begin
        samples_left <= bud_value;
      end
      if (tick_fire) begin
        phase_acc    <= phase_acc + PHASE_W'(step_hold);
        samples_left <= samples_left - BUDGET_W'(1);
      end
    end
  end

  // quadrant fold: odd quadrants read the table mirrored, upper half negated
  assign idx      = phase_acc[PHASE_W-1 -: TABLE_BITS];
  assign m_ext    = {1'b0, idx[TABLE_BITS-3:0]};
  assign rom_addr = idx[TABLE_BITS-2] ? (QUARTER - m_ext) : m_ext;

  stg_sine_rom #(
    .TABLE_BITS (TABLE_BITS)
  ) u_rom (
    .clk  (clk),
    .en   (tick_fire),
    .addr (rom_addr),
    .data (rom_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (tick_fire) begin
      s1_valid <= 1'b1;
    end else if (advance) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (tick_fire) begin
      s1_neg  <= idx[TABLE_BITS-1];
      s1_zero <= (step_hold == '0);
      s1_last <= (samples_left == BUDGET_W'(1));
    end
  end

  assign mag = {1'b0, rom_data};

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && s1_valid) begin
      if (s1_zero) begin
        out_sample <= '0;
      end else if (s1_neg) begin
        out_sample <= -$signed(mag);
      end else begin
        out_sample <= $signed(mag);
      end
      out_last <= s1_last;
    end
  end

  assign audio.valid  = out_valid;
  assign audio.sample = out_sample;
  assign audio.last   = out_last;

  `STG_ASSERT_NOW(a_busy_blocks_cmd, bud_busy, !cmd.ready, "cmd taken during budget calc")
  `STG_ASSERT_NEXT(a_pause_holds_phase, tick_fire && step_hold == '0, $stable(phase_acc), "phase moved on pause")
  `STG_ASSERT_NEXT(a_last_spends_budget, tick_fire && samples_left == BUDGET_W'(1), samples_left == '0, "budget not spent after last")
  `STG_ASSERT_NEXT(a_tick_enters_pipe, tick_fire, s1_valid, "tick lost before ROM stage")

endmodule
